[rtl/tmb_pkg.sv]
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types, command codes and field widths of the timeout timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package tmb_pkg;

    localparam int CMD_W     = 3;
    localparam int IDX_W     = 4;
    localparam int PER_W     = 16;
    localparam int TASKS_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

    typedef struct packed {
        logic             active;
        logic             expired;
        logic [PER_W-1:0] counter;
        logic [PER_W-1:0] period;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

[rtl/tmb_ram.sv]
// ----------------------------------------------------------------------------
// tmb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[rtl/tmb_entry_upd.sv]
// ----------------------------------------------------------------------------
// tmb_entry_upd
// Read-modify-write update of one timer entry for a given command.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_entry_upd (
    input  wire logic [tmb_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [tmb_pkg::PER_W-1:0] i_period,
    input  wire tmb_pkg::t_entry           i_entry,
    output tmb_pkg::t_entry                o_entry,
    output logic                           o_flag
);

    logic [tmb_pkg::PER_W-1:0] w_inc;

    // saturate the count as a safeguard
    assign w_inc = (i_entry.counter == {tmb_pkg::PER_W{1'b1}}) ?
                   i_entry.counter : i_entry.counter + 1'b1;

    always_comb begin
        o_entry = i_entry;
        case (i_cmd)
            tmb_pkg::CMD_TICK: begin
                if (i_entry.active && !i_entry.expired) begin
                    o_entry.counter = w_inc;
                    o_entry.expired = (w_inc >= i_entry.period);
                end
            end
            tmb_pkg::CMD_SET: begin
                o_entry.active  = 1'b1;
                o_entry.expired = 1'b0;
                o_entry.counter = '0;
                o_entry.period  = i_period;
            end
            tmb_pkg::CMD_CLEAR: begin
                o_entry.active  = 1'b1;
                o_entry.expired = 1'b0;
                o_entry.counter = '0;
            end
            tmb_pkg::CMD_DISABLE: begin
                o_entry = '0;
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

    assign o_flag = o_entry.active && o_entry.expired;

endmodule

`default_nettype wire

[rtl/timeout_timer_bank.sv]
// ----------------------------------------------------------------------------
// timeout_timer_bank
// Bank of one-shot timeout timers held in a RAM, one command item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) carries command items: cmd, task_index, period.
//   Master channel (o_m_*) returns one result item per command: the
//   addressed entry's expired flag (zero for tick and for invalid items).
//   All entries sit in one RAM with a registered read; each command reads
//   the entry, updates it and writes it back on the following cycle.
//   Set, clear, disable and query pass through S_CMD, then S_OUT.
//   Tick: sweeps every entry, one per cycle, then passes through S_OUT.
//   A new item is accepted once the previous result is in the output
//   register, so the block takes no new item before the last is done.
//   Reset clears a valid bit per entry; an entry never written since
//   reset reads as all zeros, so no clearing pass is needed.
//   A stalled receiver holds the result; a finished item then waits in
//   the block until the output register frees, and no item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module timeout_timer_bank #(
    parameter int TASKS = tmb_pkg::TASKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [2:0] cmd, [6:3] task_index, [22:7] period
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata    // [0] expired
);

    localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = $clog2(TASKS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_CMD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [tmb_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [tmb_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [tmb_pkg::PER_W-1:0] r_per, n_per;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [AW-1:0]             r_rd_addr, n_rd_addr;
    logic [TASKS-1:0]          r_valid, n_valid;
    logic                      r_res, n_res;
    logic                      r_ov, n_ov;
    logic                      r_od, n_od;

    logic                      w_accept;
    logic [tmb_pkg::CMD_W-1:0] w_in_cmd;
    logic [tmb_pkg::IDX_W-1:0] w_in_idx;
    logic                      w_we;
    logic [tmb_pkg::ENTRY_W-1:0] w_rd_raw;
    tmb_pkg::t_entry           w_cur;
    tmb_pkg::t_entry           w_upd;
    logic                      w_flag;
    logic                      w_cmd_ok;
    logic                      w_out_free;

    assign w_in_cmd   = i_s_tdata[2:0];
    assign w_in_idx   = i_s_tdata[6:3];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ov || i_m_tready;

    // entries not written since reset read as zero
    assign w_cur = r_valid[r_rd_addr] ? tmb_pkg::t_entry'(w_rd_raw) : '0;

    assign w_cmd_ok = (r_cmd >= tmb_pkg::CMD_SET) && (r_cmd <= tmb_pkg::CMD_QUERY) &&
                      (32'(r_idx) < 32'(TASKS));

    tmb_entry_upd u_upd (
        .i_cmd    (r_cmd),
        .i_period (r_per),
        .i_entry  (w_cur),
        .o_entry  (w_upd),
        .o_flag   (w_flag)
    );

    assign w_we = (r_state == S_TICK) ||
                  ((r_state == S_CMD) && w_cmd_ok && (r_cmd != tmb_pkg::CMD_QUERY));

    tmb_ram #(
        .WIDTH (tmb_pkg::ENTRY_W),
        .DEPTH (TASKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (r_rd_addr),
        .i_wr_data (w_upd),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_per     = r_per;
        n_cnt     = r_cnt;
        n_rd_addr = r_rd_addr;
        n_valid   = r_valid;
        n_res     = r_res;
        n_ov      = r_ov;
        n_od      = r_od;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end
        if (w_we) begin
            n_valid[r_rd_addr] = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd = w_in_cmd;
                    n_idx = w_in_idx;
                    n_per = i_s_tdata[22:7];
                    if (w_in_cmd == tmb_pkg::CMD_TICK) begin
                        n_rd_addr = '0;
                        n_cnt     = CW'(1);
                        n_state   = S_TICK;
                    end else begin
                        n_rd_addr = AW'(w_in_idx);
                        n_state   = S_CMD;
                    end
                end
            end
            S_TICK: begin
                // write back this entry, fetch the next if any
                if (32'(r_cnt) < 32'(TASKS)) begin
                    n_rd_addr = r_cnt[AW-1:0];
                    n_cnt     = r_cnt + 1'b1;
                end else begin
                    n_res   = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_CMD: begin
                n_res   = w_cmd_ok && w_flag;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_od    = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_ov    <= n_ov;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_per     <= n_per;
        r_cnt     <= n_cnt;
        r_rd_addr <= n_rd_addr;
        r_res     <= n_res;
        r_od      <= n_od;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'd0, r_od};

endmodule

`default_nettype wire

[tb/sv/timeout_timer_bank_test.sv]
// ----------------------------------------------------------------------------
// timeout_timer_bank_test
// Self-checking bench for the timeout timer bank. Command items go in on the
// slave stream and each one's expiry flag comes back on the master stream.
// A predictor keeps its own copy of the timer entries and queues the flag
// every accepted item should produce. A short directed run covers zero
// period, clear rearming, disable, tick and unknown commands. Random items
// then follow under several idling mixes, including one long receiver
// hold-off that fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module timeout_timer_bank_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tmb_pkg::*;

    localparam int          NUM_TASKS    = TASKS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // [2:0] cmd, [6:3] task_index, [22:7] period
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [0] expired

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    int unsigned cycle_count;

    class timer_bank_predictor;
        t_entry      entries [NUM_TASKS];
        logic        pending_flags [$];
        int unsigned errors;

        function new();
            for (int k = 0; k < NUM_TASKS; k++) begin
                entries[k] = '0;
            end
            errors = 0;
        endfunction

        function void note_command(logic [23:0] item);
            logic [CMD_W-1:0] op;
            logic [IDX_W-1:0] idx;
            logic [PER_W-1:0] per;
            logic             flag;
            op   = item[2:0];
            idx  = item[6:3];
            per  = item[22:7];
            flag = 1'b0;
            if (op == CMD_TICK) begin
                for (int k = 0; k < NUM_TASKS; k++) begin
                    if (entries[k].active && !entries[k].expired) begin
                        if (entries[k].counter != 16'hFFFF) begin
                            entries[k].counter = entries[k].counter + 16'd1;
                        end
                        if (entries[k].counter >= entries[k].period) begin
                            entries[k].expired = 1'b1;
                        end
                    end
                end
            end else if (op <= CMD_QUERY && int'(idx) < NUM_TASKS) begin
                case (op)
                    CMD_SET: begin
                        entries[idx].active  = 1'b1;
                        entries[idx].expired = 1'b0;
                        entries[idx].counter = '0;
                        entries[idx].period  = per;
                    end
                    CMD_CLEAR: begin
                        entries[idx].active  = 1'b1;
                        entries[idx].expired = 1'b0;
                        entries[idx].counter = '0;
                    end
                    CMD_DISABLE: begin
                        entries[idx] = '0;
                    end
                    default: begin
                    end
                endcase
                flag = entries[idx].active & entries[idx].expired;
            end
            pending_flags.push_back(flag);
        endfunction

        function void check_flag(logic actual);
            logic wanted;
            if (pending_flags.size() == 0) begin
                $error("expired: expected nothing, actual %0b", actual);
                errors++;
            end else begin
                wanted = pending_flags.pop_front();
                if (actual !== wanted) begin
                    $error("expired: expected %0b, actual %0b", wanted, actual);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return pending_flags.size();
        endfunction
    endclass

    timer_bank_predictor sb;

    timeout_timer_bank uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: a pending hold-off wins over the random stall
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_flag(o_m_tdata[0]);
        end
    end

    function automatic logic [23:0] pack_cmd(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                                             logic [PER_W-1:0] per);
        return {1'b0, per, idx, op};
    endfunction

    function automatic logic [23:0] random_item();
        int unsigned      r;
        logic [CMD_W-1:0] op;
        logic [PER_W-1:0] per;
        r = $urandom_range(99);
        if (r < 30)      op = CMD_TICK;
        else if (r < 50) op = CMD_SET;
        else if (r < 60) op = CMD_CLEAR;
        else if (r < 68) op = CMD_DISABLE;
        else if (r < 95) op = CMD_QUERY;
        else             op = 3'($urandom_range(7, 5));
        // keep most periods short so entries actually expire
        if ($urandom_range(9) == 0) per = 16'($urandom);
        else                        per = 16'($urandom_range(6));
        return pack_cmd(op, 4'($urandom_range(15)), per);
    endfunction

    // Enter and leave at a falling edge; the handshake is sampled at the rising one
    task automatic send_item(logic [23:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = item;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(item);
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        send_item(pack_cmd(CMD_QUERY,   4'd3,  16'h0000));
        send_item(pack_cmd(CMD_SET,     4'd0,  16'h0000));
        send_item(pack_cmd(CMD_QUERY,   4'd0,  16'h0000));
        send_item(pack_cmd(CMD_TICK,    4'd15, 16'hFFFF));
        send_item(pack_cmd(CMD_QUERY,   4'd0,  16'hFFFF));
        send_item(pack_cmd(CMD_SET,     4'd1,  16'h0002));
        send_item(pack_cmd(CMD_SET,     4'd15, 16'hFFFF));
        send_item(pack_cmd(CMD_TICK,    4'd0,  16'h0000));
        send_item(pack_cmd(CMD_QUERY,   4'd1,  16'h0000));
        send_item(pack_cmd(CMD_TICK,    4'd7,  16'h5555));
        send_item(pack_cmd(CMD_QUERY,   4'd1,  16'h0000));
        send_item(pack_cmd(CMD_QUERY,   4'd15, 16'h0000));
        // clear keeps the old period of two ticks
        send_item(pack_cmd(CMD_CLEAR,   4'd1,  16'hFFFF));
        send_item(pack_cmd(CMD_TICK,    4'd0,  16'h0000));
        send_item(pack_cmd(CMD_TICK,    4'd0,  16'h0000));
        send_item(pack_cmd(CMD_QUERY,   4'd1,  16'h0000));
        send_item(pack_cmd(CMD_DISABLE, 4'd0,  16'h1234));
        send_item(pack_cmd(CMD_QUERY,   4'd0,  16'h0000));
        send_item(pack_cmd(3'd5,        4'd1,  16'hFFFF));
        send_item(pack_cmd(3'd6,        4'd0,  16'h0000));
        send_item(pack_cmd(3'd7,        4'd15, 16'hAAAA));
        send_item(pack_cmd(CMD_SET,     4'd14, 16'h0001));
        send_item(pack_cmd(CMD_TICK,    4'd14, 16'h0000));
        send_item(pack_cmd(CMD_QUERY,   4'd14, 16'h0000));
        send_item(pack_cmd(CMD_DISABLE, 4'd15, 16'h0000));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        cycle_count    = 0;
        sb             = new();

        // hold reset over several rising edges, release at a falling one
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // long hold-off while items keep coming: block fills and stalls input
                    hold_left      = 300;
                end
                1: begin
                    send_idle_pct  = 77;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 77;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        i_s_tvalid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
